[src/tcsni_pkg.sv]
// ----------------------------------------------------------------------------
// tcsni_pkg
// Shared types and constants for the ClientHello server-name parser.
// ----------------------------------------------------------------------------
package tcsni_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 65535;
    localparam int unsigned POS_W = 16;
    localparam int unsigned END_W = 18;
    localparam logic [END_W-1:0] END_SAT = '1;

    localparam logic [7:0] CT_HANDSHAKE    = 8'd22;
    localparam logic [7:0] MAJOR_VERSION   = 8'd3;
    localparam logic [7:0] HS_CLIENT_HELLO = 8'd1;
    localparam logic [POS_W-1:0] RECORD_HEADER_BYTES = 16'd5;
    localparam logic [POS_W-1:0] SID_LEN_POS = 16'd43; // 9 + 2 + 32 random bytes

    localparam logic [4:0] PH_REC       = 5'd0;
    localparam logic [4:0] PH_SID_SKIP  = 5'd1;
    localparam logic [4:0] PH_CSLEN0    = 5'd2;
    localparam logic [4:0] PH_CSLEN1    = 5'd3;
    localparam logic [4:0] PH_CS0       = 5'd4;
    localparam logic [4:0] PH_CS1       = 5'd5;
    localparam logic [4:0] PH_CS_SKIP   = 5'd6;
    localparam logic [4:0] PH_COMPLEN   = 5'd7;
    localparam logic [4:0] PH_COMP_SKIP = 5'd8;
    localparam logic [4:0] PH_EXTLEN0   = 5'd9;
    localparam logic [4:0] PH_EXTLEN1   = 5'd10;
    localparam logic [4:0] PH_EH0       = 5'd11;
    localparam logic [4:0] PH_EH1       = 5'd12;
    localparam logic [4:0] PH_EH2       = 5'd13;
    localparam logic [4:0] PH_EH3       = 5'd14;
    localparam logic [4:0] PH_SNI_L0    = 5'd15;
    localparam logic [4:0] PH_SNI_L1    = 5'd16;
    localparam logic [4:0] PH_SNI_TYPE  = 5'd17;
    localparam logic [4:0] PH_SNI_N0    = 5'd18;
    localparam logic [4:0] PH_SNI_N1    = 5'd19;
    localparam logic [4:0] PH_SNI_NAME  = 5'd20;
    localparam logic [4:0] PH_EXT_SKIP  = 5'd21;
    localparam logic [4:0] PH_DONE      = 5'd22;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  name_byte;
        logic        name_restart;
        logic        accepted;
        logic [7:0]  record_minor;
        logic        suite_present;
        logic [15:0] first_suite;
        logic [15:0] name_length;
        logic        run_end;
    } out_item_t;

    // One queue entry: up to two results caused by one input byte.
    typedef struct packed {
        logic       has_name;
        logic [7:0] name_byte;
        logic       name_restart;
        logic       has_verdict;
        logic       accepted;
        logic [7:0]  record_minor;
        logic        suite_present;
        logic [15:0] first_suite;
        logic [15:0] name_length;
    } work_t;

endpackage

[src/tcsni_stream_if.sv]
// ----------------------------------------------------------------------------
// tcsni_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface tcsni_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[src/tcsni_front.sv]
// ----------------------------------------------------------------------------
// tcsni_front
// Byte-serial ClientHello walker; emits a work entry for an accepted byte that yields a name byte or ends the packet.
// ----------------------------------------------------------------------------
module tcsni_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcsni_pkg::in_item_t  in_item,
    input  logic                 in_fire,
    output tcsni_pkg::work_t     work,
    output logic                 work_valid
);
    import tcsni_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [4:0]       phase_reg, phase_next;
    logic [23:0]      acc_reg, acc_next;
    logic [END_W-1:0] req_reg, req_next;
    logic [END_W-1:0] ext_end_reg, ext_end_next;
    logic [END_W-1:0] data_end_reg, data_end_next;
    logic [15:0]      left_reg, left_next;
    logic [15:0]      suite_reg, suite_next;
    logic             suite_flag_reg, suite_flag_next;
    logic [7:0]       minor_reg, minor_next;
    logic [15:0]      nlen_reg, nlen_next;
    logic             failed_reg, failed_next;

    // Current view of state; start-of-packet values on a first byte.
    logic [POS_W-1:0] p;
    logic [4:0]       ph;
    logic [23:0]      acc;
    logic [END_W-1:0] req, ext_end, data_end;
    logic [15:0]      left, suite, nlen;
    logic             sflag, failed;
    logic [7:0]       minor, b;

    logic [END_W-1:0] p1, eh_end, hs_end;
    logic [15:0]      v16;
    logic             emit, ok;

    always_comb
    begin
        b = in_item.data_byte;
        if (in_item.first_byte) begin
            p = '0; ph = PH_REC; acc = '0; req = '0; ext_end = '0; data_end = '0;
            left = '0; suite = '0; sflag = 1'b0; minor = '0; nlen = '0; failed = 1'b0;
        end else begin
            p = pos_reg; ph = phase_reg; acc = acc_reg; req = req_reg;
            ext_end = ext_end_reg; data_end = data_end_reg; left = left_reg;
            suite = suite_reg; sflag = suite_flag_reg; minor = minor_reg;
            nlen = nlen_reg; failed = failed_reg;
        end

        pos_next = p; phase_next = ph; acc_next = acc; req_next = req;
        ext_end_next = ext_end; data_end_next = data_end; left_next = left;
        suite_next = suite; suite_flag_next = sflag; minor_next = minor;
        nlen_next = nlen; failed_next = failed;
        emit = 1'b0;
        work = '0;

        p1 = {2'b00, p} + END_W'(1);
        v16 = {acc[7:0], b};
        eh_end = p1 + {2'b00, acc[15:8], b};
        hs_end = '0;

        if (32'(p) >= MAX_PACKET_BYTES) begin
            failed_next = 1'b1;
        end else begin
            pos_next = p + POS_W'(1);
            if (!failed) begin
                unique case (ph)
                    PH_REC:
                    begin
                        if (p == '0 && b != CT_HANDSHAKE) failed_next = 1'b1;
                        else if (p == POS_W'(1) && b != MAJOR_VERSION) failed_next = 1'b1;
                        else if (p == POS_W'(2)) minor_next = b;
                        else if (p == RECORD_HEADER_BYTES && b != HS_CLIENT_HELLO)
                            failed_next = 1'b1;
                        else if (p >= POS_W'(6) && p <= POS_W'(8)) begin
                            acc_next = {acc[15:0], b};
                            if (p == POS_W'(8)) begin
                                // 9 + 24-bit length; past 16 bits it is never reached
                                if (acc[15:8] != '0) hs_end = END_SAT;
                                else hs_end = END_W'({acc[7:0], b}) + END_W'(9);
                                if (hs_end > req) req_next = hs_end;
                            end
                        end else if (p == SID_LEN_POS) begin
                            data_end_next = p1 + END_W'(b);
                            phase_next = (b == 8'd0) ? PH_CSLEN0 : PH_SID_SKIP;
                        end
                    end
                    PH_SID_SKIP:
                        if (p1 >= data_end) phase_next = PH_CSLEN0;
                    PH_CSLEN0:
                    begin
                        acc_next = {16'd0, b};
                        phase_next = PH_CSLEN1;
                    end
                    PH_CSLEN1:
                    begin
                        data_end_next = p1 + END_W'(v16);
                        if (v16 >= 16'd2) phase_next = PH_CS0;
                        else if (v16 == 16'd1) phase_next = PH_CS_SKIP;
                        else phase_next = PH_COMPLEN;
                    end
                    PH_CS0:
                    begin
                        acc_next = {16'd0, b};
                        phase_next = PH_CS1;
                    end
                    PH_CS1:
                    begin
                        suite_next = v16;
                        suite_flag_next = 1'b1;
                        phase_next = (p1 >= data_end) ? PH_COMPLEN : PH_CS_SKIP;
                    end
                    PH_CS_SKIP:
                        if (p1 >= data_end) phase_next = PH_COMPLEN;
                    PH_COMPLEN:
                    begin
                        data_end_next = p1 + END_W'(b);
                        phase_next = (b == 8'd0) ? PH_EXTLEN0 : PH_COMP_SKIP;
                    end
                    PH_COMP_SKIP:
                        if (p1 >= data_end) phase_next = PH_EXTLEN0;
                    PH_EXTLEN0:
                    begin
                        acc_next = {16'd0, b};
                        phase_next = PH_EXTLEN1;
                    end
                    PH_EXTLEN1:
                    begin
                        ext_end_next = p1 + END_W'(v16);
                        if (ext_end_next > req) req_next = ext_end_next;
                        phase_next = (p1 + END_W'(4) > ext_end_next) ? PH_DONE : PH_EH0;
                    end
                    PH_EH0:
                    begin
                        acc_next = {16'd0, b};
                        phase_next = PH_EH1;
                    end
                    PH_EH1:
                    begin
                        acc_next = {23'd0, (v16 == 16'd0)};
                        phase_next = PH_EH2;
                    end
                    PH_EH2:
                    begin
                        acc_next = {7'd0, acc[0], b, 8'd0};
                        phase_next = PH_EH3;
                    end
                    PH_EH3:
                    begin
                        data_end_next = eh_end;
                        if (eh_end > ext_end) phase_next = PH_DONE;
                        else if (acc[16] && {acc[15:8], b} > 16'd5) phase_next = PH_SNI_L0;
                        else if (p1 >= eh_end)
                            phase_next = (eh_end + END_W'(4) > ext_end) ? PH_DONE : PH_EH0;
                        else phase_next = PH_EXT_SKIP;
                    end
                    PH_SNI_L0: phase_next = PH_SNI_L1;
                    PH_SNI_L1: phase_next = PH_SNI_TYPE;
                    PH_SNI_TYPE:
                    begin
                        acc_next = {23'd0, (b == 8'd0)};
                        phase_next = PH_SNI_N0;
                    end
                    PH_SNI_N0:
                    begin
                        acc_next = {15'd0, acc[0], b};
                        phase_next = PH_SNI_N1;
                    end
                    PH_SNI_N1:
                    begin
                        if (acc[8] && p1 + END_W'(v16) <= data_end) begin
                            nlen_next = v16;
                            left_next = v16;
                        end
                        if (acc[8] && p1 + END_W'(v16) <= data_end && v16 != 16'd0)
                            phase_next = PH_SNI_NAME;
                        else if (p1 >= data_end)
                            phase_next = (data_end + END_W'(4) > ext_end) ? PH_DONE : PH_EH0;
                        else phase_next = PH_EXT_SKIP;
                    end
                    PH_SNI_NAME:
                    begin
                        emit = 1'b1;
                        work.has_name = 1'b1;
                        work.name_byte = b;
                        work.name_restart = (left == nlen);
                        left_next = left - 16'd1;
                        if (left_next == 16'd0) begin
                            if (p1 >= data_end)
                                phase_next = (data_end + END_W'(4) > ext_end) ? PH_DONE
                                                                             : PH_EH0;
                            else phase_next = PH_EXT_SKIP;
                        end
                    end
                    PH_EXT_SKIP:
                        if (p1 >= data_end)
                            phase_next = (data_end + END_W'(4) > ext_end) ? PH_DONE : PH_EH0;
                    default: ;
                endcase
            end
        end

        ok = !failed_next && phase_next >= PH_EH0 && phase_next <= PH_DONE
             && {2'b00, pos_next} >= req_next;
        if (in_item.last_byte) begin
            work.has_verdict = 1'b1;
            work.accepted = ok;
            if (ok) begin
                work.record_minor = minor_next;
                work.suite_present = suite_flag_next;
                work.first_suite = suite_next;
                work.name_length = nlen_next;
            end
        end
        work_valid = in_fire && (emit || in_item.last_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0; phase_reg <= PH_REC; acc_reg <= '0; req_reg <= '0;
            ext_end_reg <= '0; data_end_reg <= '0; left_reg <= '0; suite_reg <= '0;
            suite_flag_reg <= 1'b0; minor_reg <= '0; nlen_reg <= '0; failed_reg <= 1'b0;
        end else if (in_fire) begin
            if (in_item.last_byte) begin
                pos_reg <= '0; phase_reg <= PH_REC; acc_reg <= '0; req_reg <= '0;
                ext_end_reg <= '0; data_end_reg <= '0; left_reg <= '0; suite_reg <= '0;
                suite_flag_reg <= 1'b0; minor_reg <= '0; nlen_reg <= '0;
                failed_reg <= 1'b0;
            end else begin
                pos_reg <= pos_next; phase_reg <= phase_next; acc_reg <= acc_next;
                req_reg <= req_next; ext_end_reg <= ext_end_next;
                data_end_reg <= data_end_next; left_reg <= left_next;
                suite_reg <= suite_next; suite_flag_reg <= suite_flag_next;
                minor_reg <= minor_next; nlen_reg <= nlen_next; failed_reg <= failed_next;
            end
        end
    end

endmodule

[src/tcsni_queue.sv]
// ----------------------------------------------------------------------------
// tcsni_queue
// Four-entry FIFO of work entries between walker and output stage.
// ----------------------------------------------------------------------------
module tcsni_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tcsni_pkg::work_t  push_data,
    input  logic              pop,
    output tcsni_pkg::work_t  head,
    output logic              not_empty,
    output logic              has_room
);
    import tcsni_pkg::*;

    work_t      mem [4];
    logic [1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_next = push ? wr_reg + 2'd1 : wr_reg;
        rd_next = pop ? rd_reg + 2'd1 : rd_reg;
        cnt_next = cnt_reg + 3'(push) - 3'(pop);
        head = mem[rd_reg];
        not_empty = cnt_reg != 3'd0;
        // room only if a second write cannot follow into a full queue
        has_room = cnt_reg < 3'd3;
    end

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0;
        end else begin
            wr_reg <= wr_next; rd_reg <= rd_next; cnt_reg <= cnt_next;
        end
    end

endmodule

[src/tcsni_back.sv]
// ----------------------------------------------------------------------------
// tcsni_back
// Splits each work entry into name-byte and verdict result items.
// ----------------------------------------------------------------------------
module tcsni_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tcsni_pkg::work_t   head,
    input  logic               not_empty,
    output logic               pop,
    tcsni_stream_if.source     out_ch
);
    import tcsni_pkg::*;

    logic      name_done_reg, name_done_next;
    logic      send_name, both;
    out_item_t item;

    always_comb
    begin
        send_name = head.has_name && !name_done_reg;
        both = head.has_name && head.has_verdict;
        item = '0;
        if (send_name) begin
            item.name_byte = head.name_byte;
            item.name_restart = head.name_restart;
            item.run_end = !head.has_verdict;
        end else begin
            item.kind = 1'b1;
            item.accepted = head.accepted;
            item.record_minor = head.record_minor;
            item.suite_present = head.suite_present;
            item.first_suite = head.first_suite;
            item.name_length = head.name_length;
            item.run_end = 1'b1;
        end
        out_ch.valid = not_empty;
        out_ch.payload = item;
        pop = not_empty && out_ch.ready && !(send_name && both);
        name_done_next = name_done_reg;
        if (not_empty && out_ch.ready)
            name_done_next = send_name && both;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) name_done_reg <= 1'b0;
        else name_done_reg <= name_done_next;
    end

endmodule

[src/tls_client_hello_sni_parser.sv]
// Timing: results are offered from work entries registered in the work queue.
// Throughput: 1 byte per cycle while the queue has room; a byte that yields a name
// byte and a verdict gives two output items, absorbed by the 4-entry work queue.
// Reset: asynchronous active-low rst_n clears the walker and empties the queue.
// ----------------------------------------------------------------------------
// tls_client_hello_sni_parser
// Streams packet bytes, extracts the SNI host name and gives a packet verdict.
// ----------------------------------------------------------------------------
module tls_client_hello_sni_parser (
    input  logic           clk,
    input  logic           rst_n,
    tcsni_stream_if.sink   in_ch,
    tcsni_stream_if.source out_ch
);
    import tcsni_pkg::*;

    work_t work, head;
    logic  work_valid, not_empty, has_room, pop, in_fire;

    assign in_ch.ready = has_room;
    assign in_fire = in_ch.valid && has_room;

    tcsni_front u_front (
        .clk(clk), .rst_n(rst_n), .in_item(in_ch.payload), .in_fire(in_fire),
        .work(work), .work_valid(work_valid)
    );

    tcsni_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(work_valid), .push_data(work), .pop(pop),
        .head(head), .not_empty(not_empty), .has_room(has_room)
    );

    tcsni_back u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .not_empty(not_empty), .pop(pop),
        .out_ch(out_ch)
    );

endmodule
